// File: design/u8s_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u8s_pkg
// Shared types, constants and the sequence judge for the UTF-8 sanitizer.
// ----------------------------------------------------------------------------
package u8s_pkg;

    localparam int CAP_W       = 13;
    localparam int IN_Q_DEPTH  = 2;   // power of two
    localparam int OUT_Q_DEPTH = 4;   // power of two

    // Replacement character U+FFFD; entry 3 is padding and never emitted
    localparam logic [3:0][7:0] REPL = {8'h00, 8'hBD, 8'hBF, 8'hEF};

    localparam logic [7:0] LEAD_2_MIN = 8'hC2;
    localparam logic [7:0] LEAD_4_MAX = 8'hF4;
    localparam logic [7:0] LEAD_E0    = 8'hE0;
    localparam logic [7:0] LEAD_ED    = 8'hED;
    localparam logic [7:0] LEAD_F0    = 8'hF0;
    localparam logic [7:0] LEAD_F4    = 8'hF4;
    localparam logic [7:0] CONT_A0    = 8'hA0;
    localparam logic [7:0] CONT_90    = 8'h90;
    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_TAG   = 8'h80;

    typedef enum logic [1:0] {
        VERDICT_INVALID,
        VERDICT_PARTIAL,
        VERDICT_COMPLETE
    } verdict_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_JUDGE,
        ST_EMIT,
        ST_TERM
    } back_state_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       term;
    } item_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       last;
    } result_t;

    typedef struct packed {
        verdict_t   verdict;
        logic [2:0] len;
    } judge_t;

    function automatic logic is_cont(input logic [7:0] b);
        return (b & CONT_MASK) == CONT_TAG;
    endfunction

    // Judge the first n bytes (1..4) of buf
    function automatic judge_t judge(input logic [3:0][7:0] buf_in, input logic [2:0] n);
        judge_t     r;
        logic [7:0] c;
        logic [2:0] need;
        logic       bad;
        c    = buf_in[0];
        bad  = 1'b0;
        need = 3'd1;
        if (c[7] == 1'b0)
        begin
            need = 3'd1;
        end
        else if (c[7:5] == 3'b110)
        begin
            need = 3'd2;
            bad  = c < LEAD_2_MIN;
        end
        else if (c[7:4] == 4'b1110)
        begin
            need = 3'd3;
        end
        else if (c[7:3] == 5'b11110)
        begin
            need = 3'd4;
            bad  = c > LEAD_4_MAX;
        end
        else
        begin
            bad = 1'b1;
        end
        if (n > 3'd1 && need > 3'd1)
        begin
            if (!is_cont(buf_in[1])) bad = 1'b1;
            if (c == LEAD_E0 && buf_in[1] < CONT_A0) bad = 1'b1;
            if (c == LEAD_ED && buf_in[1] >= CONT_A0) bad = 1'b1;
            if (c == LEAD_F0 && buf_in[1] < CONT_90) bad = 1'b1;
            if (c == LEAD_F4 && buf_in[1] >= CONT_90) bad = 1'b1;
        end
        if (n > 3'd2 && need > 3'd2 && !is_cont(buf_in[2])) bad = 1'b1;
        if (n > 3'd3 && need > 3'd3 && !is_cont(buf_in[3])) bad = 1'b1;
        r.len = need;
        if (bad) r.verdict = VERDICT_INVALID;
        else if (n >= need) r.verdict = VERDICT_COMPLETE;
        else r.verdict = VERDICT_PARTIAL;
        return r;
    endfunction

endpackage
`default_nettype wire

// File: design/utf8_sanitizer_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_sanitizer_top
// Streaming UTF-8 validator that replaces offending bytes with U+FFFD.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: push a string byte when full is low; a zero byte ends
//   the string. Result channel: while empty is low, out_byte/last carry the
//   oldest result; pop takes it. The terminator comes out as a zero byte
//   with last set (nothing at all when capacity is zero).
//   Configuration: cfg_data is the output buffer capacity in bytes,
//   terminator included, written when cfg_valid is high (cfg_ready is always
//   high). Write it only while no string is in flight. Reset value is 256.
//   Path: a byte passes the input queue, the sequencer's load, judge and
//   emit states and the result queue on its way to the result ports. The
//   sequencer emits one byte a cycle while the result queue has room, and
//   loads and then judges each input byte; it takes no new input byte
//   until it has emitted or held the last one.
//   A stalled receiver fills the result queue, holds the sequencer and then
//   raises full; nothing is lost. Reset clears all queues and held bytes.
// ----------------------------------------------------------------------------
module utf8_sanitizer_top
    import u8s_pkg::*;
#(
    parameter int MAX_CAPACITY = 4096
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    output logic                  full,
    input  wire logic [7:0]       in_byte,
    output logic                  empty,
    input  wire logic             pop,
    output logic [7:0]            out_byte,
    output logic                  last,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [CAP_W-1:0] cfg_data
);

    logic [CAP_W-1:0] capacity_reg;
    logic [CAP_W-1:0] cap_eff;
    item_t            item;
    logic             item_pop;
    result_t          res;
    logic             res_full;

    assign cfg_ready = 1'b1;

    // hold the capacity; values above the build limit act as the limit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            capacity_reg <= CAP_W'(256);
        else if (cfg_valid && cfg_ready)
            capacity_reg <= cfg_data;
    end

    assign cap_eff = (int'(capacity_reg) > MAX_CAPACITY) ? CAP_W'(MAX_CAPACITY)
                                                         : capacity_reg;

    // front: accept and tag bytes
    u8s_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .in_byte  (in_byte),
        .item     (item),
        .item_pop (item_pop)
    );

    // back: judge held sequences and emit bytes one a cycle while the result queue has room
    u8s_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cap_eff  (cap_eff),
        .item     (item),
        .item_pop (item_pop),
        .res      (res),
        .res_full (res_full)
    );

    // result queue towards the receiver
    u8s_out_q u_out_q (
        .clk      (clk),
        .rst_n    (rst_n),
        .res      (res),
        .res_full (res_full),
        .empty    (empty),
        .pop      (pop),
        .out_byte (out_byte),
        .last     (last)
    );

`ifndef SYNTHESIS
    // the terminator is always a zero byte
    a_last_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.last |-> res.data == 8'h00)
        else $error("terminator result carries a nonzero byte");

    // a result blocked by a full queue is held unchanged
    a_res_held: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res_full |=> res.valid && $stable(res.data) && $stable(res.last))
        else $error("blocked result changed before it was queued");

    // the sequencer takes an item only when one is waiting
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        item_pop |-> item.valid)
        else $error("item taken from an empty input queue");
`endif

endmodule
`default_nettype wire

// File: design/u8s_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u8s_front
// Input queue: accepts string bytes and tags the terminating zero byte.
// ----------------------------------------------------------------------------
module u8s_front
    import u8s_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] in_byte,
    output item_t           item,
    input  wire logic       item_pop
);

    localparam int PTR_W = (IN_Q_DEPTH > 1) ? $clog2(IN_Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(IN_Q_DEPTH + 1);

    typedef struct packed {
        logic [7:0] data;
        logic       term;
    } entry_t;

    entry_t             mem_reg [IN_Q_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign full    = count_reg == CNT_W'(IN_Q_DEPTH);
    assign do_push = push && !full;
    assign do_pop  = item_pop && count_reg != '0;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop) count_next = count_reg + 1'b1;
        else if (do_pop && !do_push) count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop) rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    // classify on entry: only the zero byte ends a string
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg].data <= in_byte;
            mem_reg[wr_ptr_reg].term <= in_byte == 8'h00;
        end
    end

    always_comb
    begin
        item.valid = count_reg != '0;
        item.data  = mem_reg[rd_ptr_reg].data;
        item.term  = mem_reg[rd_ptr_reg].term;
    end

endmodule
`default_nettype wire

// File: design/u8s_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u8s_back
// Sequencer: holds the open sequence, judges it, emits a byte a cycle if not full.
// ----------------------------------------------------------------------------
module u8s_back
    import u8s_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [CAP_W-1:0] cap_eff,
    input  wire item_t            item,
    output logic                  item_pop,
    output result_t               res,
    input  wire logic             res_full
);

    back_state_t      state_reg, state_next;
    logic [3:0][7:0]  wb_reg, wb_next;
    logic [2:0]       wn_reg, wn_next;
    logic             at_end_reg, at_end_next;
    logic             trunc_reg, trunc_next;
    logic [CAP_W-1:0] written_reg, written_next;
    logic [1:0]       k_reg, k_next;
    logic [2:0]       size_reg, size_next;
    logic [2:0]       shift_reg, shift_next;
    logic             repl_reg, repl_next;
    judge_t           jr;
    logic [2:0]       size_c, wn_after;
    logic [3:0]       src_idx;

    assign jr       = judge(wb_reg, wn_reg);
    assign size_c   = (jr.verdict == VERDICT_COMPLETE) ? jr.len : 3'd3;
    assign wn_after = wn_reg - shift_reg;

    always_comb
    begin
        state_next   = state_reg;
        wb_next      = wb_reg;
        wn_next      = wn_reg;
        at_end_next  = at_end_reg;
        trunc_next   = trunc_reg;
        written_next = written_reg;
        k_next       = k_reg;
        size_next    = size_reg;
        shift_next   = shift_reg;
        repl_next    = repl_reg;
        item_pop     = 1'b0;
        res.valid    = 1'b0;
        res.data     = repl_reg ? REPL[k_reg] : wb_reg[k_reg];
        res.last     = 1'b0;
        src_idx      = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item.valid)
                begin
                    item_pop = 1'b1;
                    if (item.term)
                    begin
                        at_end_next = 1'b1;
                        state_next  = ST_JUDGE;
                    end
                    else if (!trunc_reg)
                    begin
                        wb_next[wn_reg[1:0]] = item.data;
                        wn_next     = wn_reg + 3'd1;
                        at_end_next = 1'b0;
                        state_next  = ST_JUDGE;
                    end
                end
            end
            ST_JUDGE:
            begin
                if (trunc_reg || wn_reg == 3'd0)
                begin
                    wn_next    = '0;
                    state_next = at_end_reg ? ST_TERM : ST_IDLE;
                end
                else if (jr.verdict == VERDICT_PARTIAL && !at_end_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if ({1'b0, written_reg} + {{(CAP_W-2){1'b0}}, size_c}
                         >= {1'b0, cap_eff})
                begin
                    // does not fit: drop the held bytes and the rest of the string
                    trunc_next = 1'b1;
                    wn_next    = '0;
                    state_next = at_end_reg ? ST_TERM : ST_IDLE;
                end
                else
                begin
                    size_next  = size_c;
                    shift_next = (jr.verdict == VERDICT_COMPLETE) ? jr.len : 3'd1;
                    repl_next  = jr.verdict != VERDICT_COMPLETE;
                    k_next     = '0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                res.valid = 1'b1;
                if (!res_full)
                begin
                    k_next = k_reg + 2'd1;
                    if ({1'b0, k_reg} == size_reg - 3'd1)
                    begin
                        written_next = written_reg + {{(CAP_W-3){1'b0}}, size_reg};
                        for (int i = 0; i < 4; i++)
                        begin
                            src_idx = 4'(i) + {1'b0, shift_reg};
                            wb_next[i] = (src_idx < 4'd4) ? wb_reg[src_idx[1:0]] : 8'h00;
                        end
                        wn_next = wn_after;
                        if (wn_after == 3'd0)
                            state_next = at_end_reg ? ST_TERM : ST_IDLE;
                        else
                            state_next = ST_JUDGE;
                    end
                end
            end
            ST_TERM:
            begin
                res.data  = 8'h00;
                res.last  = 1'b1;
                res.valid = cap_eff != '0;
                if (cap_eff == '0 || !res_full)
                begin
                    wn_next      = '0;
                    at_end_next  = 1'b0;
                    trunc_next   = 1'b0;
                    written_next = '0;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            wn_reg      <= '0;
            at_end_reg  <= 1'b0;
            trunc_reg   <= 1'b0;
            written_reg <= '0;
            k_reg       <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            wn_reg      <= wn_next;
            at_end_reg  <= at_end_next;
            trunc_reg   <= trunc_next;
            written_reg <= written_next;
            k_reg       <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wb_reg    <= wb_next;
        size_reg  <= size_next;
        shift_reg <= shift_next;
        repl_reg  <= repl_next;
    end

endmodule
`default_nettype wire

// File: design/u8s_out_q.sv
`default_nettype none
// ----------------------------------------------------------------------------
// u8s_out_q
// Result queue: parts the sequencer from the receiver.
// ----------------------------------------------------------------------------
module u8s_out_q
    import u8s_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire result_t res,
    output logic         res_full,
    output logic         empty,
    input  wire logic    pop,
    output logic [7:0]   out_byte,
    output logic         last
);

    localparam int PTR_W = (OUT_Q_DEPTH > 1) ? $clog2(OUT_Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(OUT_Q_DEPTH + 1);

    logic [7:0]       data_reg [OUT_Q_DEPTH];
    logic             last_reg [OUT_Q_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign res_full = count_reg == CNT_W'(OUT_Q_DEPTH);
    assign empty    = count_reg == '0;
    assign do_push  = res.valid && !res_full;
    assign do_pop   = pop && !empty;
    assign out_byte = data_reg[rd_ptr_reg];
    assign last     = last_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop) count_next = count_reg + 1'b1;
        else if (do_pop && !do_push) count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop) rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            data_reg[wr_ptr_reg] <= res.data;
            last_reg[wr_ptr_reg] <= res.last;
        end
    end

endmodule
`default_nettype wire

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the streaming UTF-8 sanitizer. A clocked driver
// feeds string bytes from a pending queue, a clocked monitor pops results,
// and a behavioural predictor inside the bench works out the sanitized
// byte stream that every accepted transaction must produce.
// ----------------------------------------------------------------------------
module tb
    import u8s_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_CAP        = 4096;
    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam int SETTLE_CYCLES  = 40;     // well past a byte's path through the block
    localparam int SQUEEZE_CYCLES = 400;
    localparam int RND_ITEMS      = 400;

    // U+FFFD in UTF-8, first byte at index 0
    localparam logic [2:0][7:0] FFFD_BYTES = {8'hBD, 8'hBF, 8'hEF};

    // Idling styles for either side of the block
    localparam int IDLE_NONE = 0;
    localparam int IDLE_SOME = 1;
    localparam int IDLE_HARD = 2;

    typedef struct packed {
        logic [7:0] value;
        logic       term;
    } clean_t;

    typedef struct {
        logic [7:0] value;
        int         gap;
    } raw_t;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             push      = 1'b0;
    logic [7:0]       in_byte   = 8'h00;
    logic             pop       = 1'b0;
    logic             cfg_valid = 1'b0;
    logic [CAP_W-1:0] cfg_data  = '0;
    logic             full;
    logic             empty;
    logic [7:0]       out_byte;
    logic             last;
    logic             cfg_ready;

    utf8_sanitizer_top #(
        .MAX_CAPACITY (MAX_CAP)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_byte   (in_byte),
        .empty     (empty),
        .pop       (pop),
        .out_byte  (out_byte),
        .last      (last),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Pending string bytes and the sanitized bytes they must turn into
    raw_t   raw_q[$];
    clean_t clean_q[$];

    int queued_cnt = 0;
    int sent_cnt   = 0;
    int err_cnt    = 0;
    int cycle_cnt  = 0;

    int tx_mode = IDLE_SOME;
    int rx_mode = IDLE_SOME;
    int tx_wait = 0;
    int rx_wait = 0;
    bit tx_busy    = 1'b0;
    bit tx_taken   = 1'b0;
    bit rx_taken   = 1'b0;
    bit stall_rx   = 1'b0;
    bit squeeze_go = 1'b0;
    raw_t tx_cur;

    // ------------------------------------------------------------------------
    // Predictor state: held bytes of an unfinished sequence, bytes written in
    // the current string, the truncation flag and the capacity register.
    // ------------------------------------------------------------------------
    logic [7:0]       held [3] = '{8'h00, 8'h00, 8'h00};
    int               held_n    = 0;
    int               out_cnt   = 0;
    bit               trunc     = 1'b0;
    logic [CAP_W-1:0] cap_model = 13'd256;
    logic [7:0]       work [4];

    // Register values above the maximum act as the maximum
    function automatic int cap_limit();
        return (cap_model > MAX_CAP) ? MAX_CAP : int'(cap_model);
    endfunction

    // Judge the first n bytes of the work buffer; need gets the sequence size
    function automatic verdict_t classify(input int n, output int need);
        logic [7:0] lead;
        int         have;
        lead = work[0];
        need = 1;
        if (lead[7] == 1'b0)
        begin
            need = 1;
        end
        else if (lead[7:5] == 3'b110)
        begin
            need = 2;
            if (lead < 8'hC2) return VERDICT_INVALID;    // overlong two-byte form
        end
        else if (lead[7:4] == 4'b1110)
        begin
            need = 3;
        end
        else if (lead[7:3] == 5'b11110)
        begin
            need = 4;
            if (lead > 8'hF4) return VERDICT_INVALID;    // beyond U+10FFFF
        end
        else
        begin
            return VERDICT_INVALID;                      // continuation or F8..FF
        end
        have = (n < need) ? n : need;
        for (int k = 1; k < have; k++)
        begin
            if (work[k][7:6] != 2'b10) return VERDICT_INVALID;
            if (k == 1)
            begin
                if (lead == 8'hE0 && work[1] < 8'hA0) return VERDICT_INVALID;
                if (lead == 8'hED && work[1] >= 8'hA0) return VERDICT_INVALID;
                if (lead == 8'hF0 && work[1] < 8'h90) return VERDICT_INVALID;
                if (lead == 8'hF4 && work[1] >= 8'h90) return VERDICT_INVALID;
            end
        end
        return (n >= need) ? VERDICT_COMPLETE : VERDICT_PARTIAL;
    endfunction

    // Write n bytes (the sequence or U+FFFD) if they fit, else truncate
    function automatic void emit(input int n, input bit repl);
        clean_t c;
        if (trunc) return;
        if (out_cnt + n >= cap_limit())
        begin
            trunc = 1'b1;
            return;
        end
        for (int k = 0; k < n; k++)
        begin
            c.value = repl ? FFFD_BYTES[k] : work[k];
            c.term  = 1'b0;
            clean_q.push_back(c);
        end
        out_cnt += n;
    endfunction

    function automatic void drain(input int n, input bit at_end);
        int       len;
        verdict_t v;
        while (n > 0 && !trunc)
        begin
            v = classify(n, len);
            if (v == VERDICT_PARTIAL && !at_end) break;
            if (v == VERDICT_COMPLETE)
            begin
                emit(len, 1'b0);
            end
            else
            begin
                emit(3, 1'b1);
                len = 1;
            end
            for (int k = len; k < n; k++) work[k - len] = work[k];
            n -= len;
        end
        if (trunc) n = 0;
        held_n = n;
        for (int k = 0; k < 3; k++) held[k] = (k < n) ? work[k] : 8'h00;
    endfunction

    // Advance the predictor by one accepted string byte
    function automatic void sanitize_byte(input logic [7:0] x);
        clean_t t;
        for (int k = 0; k < 3; k++) work[k] = held[k];
        work[3] = 8'h00;
        if (x != 8'h00)
        begin
            if (trunc) return;
            work[held_n] = x;
            drain(held_n + 1, 1'b0);
        end
        else
        begin
            drain(held_n, 1'b1);
            if (cap_limit() != 0)
            begin
                t.value = 8'h00;
                t.term  = 1'b1;
                clean_q.push_back(t);
            end
            for (int k = 0; k < 3; k++) held[k] = 8'h00;
            held_n  = 0;
            out_cnt = 0;
            trunc   = 1'b0;
        end
    endfunction

    function automatic int draw_gap(input int mode);
        if (mode == IDLE_NONE) return 0;
        if (mode == IDLE_SOME) return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 12) : 0;
        return $urandom_range(0, 12);
    endfunction

    task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
        if (err_cnt < 50)
            $display("mismatch at cycle %0d: %s got %02h, want %02h", cycle_cnt, what, got, want);
        err_cnt++;
    endtask

    // ------------------------------------------------------------------------
    // Clock, watchdog
    // ------------------------------------------------------------------------
    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: sample every handshake at the rising edge. Predict first, then
    // compare, so a transaction in and a result out on the same edge still
    // line up.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        clean_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready) cap_model = cfg_data;
            if (push && !full)
            begin
                sanitize_byte(in_byte);
                tx_taken = 1'b1;
                sent_cnt++;
            end
            if (pop && !empty)
            begin
                rx_taken = 1'b1;
                if (clean_q.size() == 0)
                begin
                    report("result with nothing expected", out_byte, 8'h00);
                end
                else
                begin
                    want = clean_q.pop_front();
                    if (out_byte !== want.value) report("out_byte", out_byte, want.value);
                    if (last !== want.term) report("last", {7'd0, last}, {7'd0, want.term});
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Driver: on the falling edge retire the transaction seen at the last
    // rising edge, fetch the next pending byte and sit out its gap. Push is
    // written once per edge so a back-to-back stream keeps it high.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (tx_taken)
            begin
                tx_taken = 1'b0;
                tx_busy  = 1'b0;
            end
            if (!tx_busy && raw_q.size() > 0)
            begin
                tx_cur  = raw_q.pop_front();
                tx_busy = 1'b1;
                tx_wait = tx_cur.gap;
            end
            if (tx_busy && tx_wait == 0)
            begin
                push    <= 1'b1;
                in_byte <= tx_cur.value;
            end
            else
            begin
                push <= 1'b0;
                if (tx_busy) tx_wait--;
            end
        end
    end

    // Receiver: draw a fresh wait after each result; a squeeze overrides all
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (rx_taken)
            begin
                rx_taken = 1'b0;
                rx_wait  = draw_gap(rx_mode);
            end
            if (stall_rx)
            begin
                pop <= 1'b0;
            end
            else if (rx_wait > 0)
            begin
                rx_wait--;
                pop <= 1'b0;
            end
            else
            begin
                pop <= 1'b1;
            end
        end
    end

    // Hold the receiver off for a long stretch so both queues fill and full rises
    initial
    begin
        wait (squeeze_go);
        @(posedge clk);
        stall_rx = 1'b1;
        repeat (SQUEEZE_CYCLES) @(posedge clk);
        stall_rx = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic add_byte(input logic [7:0] v);
        raw_t r;
        r.value = v;
        r.gap   = draw_gap(tx_mode);
        raw_q.push_back(r);
        queued_cnt++;
    endtask

    function automatic logic [7:0] cont_byte();
        return 8'($urandom_range(8'h80, 8'hBF));
    endfunction

    // Build a well-formed sequence of n bytes with random content
    function automatic logic [3:0][7:0] make_valid(input int n);
        logic [3:0][7:0] s;
        for (int k = 0; k < 4; k++) s[k] = cont_byte();
        case (n)
            2: s[0] = 8'($urandom_range(8'hC2, 8'hDF));
            3:
            begin
                s[0] = 8'($urandom_range(8'hE0, 8'hEF));
                if (s[0] == 8'hE0) s[1] = 8'($urandom_range(8'hA0, 8'hBF));
                if (s[0] == 8'hED) s[1] = 8'($urandom_range(8'h80, 8'h9F));
            end
            default:
            begin
                s[0] = 8'($urandom_range(8'hF0, 8'hF4));
                if (s[0] == 8'hF0) s[1] = 8'($urandom_range(8'h90, 8'hBF));
                if (s[0] == 8'hF4) s[1] = 8'($urandom_range(8'h80, 8'h8F));
            end
        endcase
        return s;
    endfunction

    // Overlong, surrogate, out-of-range and illegal lead forms
    task automatic add_bad();
        case ($urandom_range(0, 5))
            0:
            begin
                add_byte(8'($urandom_range(8'hC0, 8'hC1)));
                add_byte(cont_byte());
            end
            1:
            begin
                add_byte(8'hE0);
                add_byte(8'($urandom_range(8'h80, 8'h9F)));
                add_byte(cont_byte());
            end
            2:
            begin
                add_byte(8'hED);
                add_byte(8'($urandom_range(8'hA0, 8'hBF)));
                add_byte(cont_byte());
            end
            3:
            begin
                add_byte(8'hF0);
                add_byte(8'($urandom_range(8'h80, 8'h8F)));
                add_byte(cont_byte());
                add_byte(cont_byte());
            end
            4:
            begin
                add_byte(8'hF4);
                add_byte(8'($urandom_range(8'h90, 8'hBF)));
                add_byte(cont_byte());
                add_byte(cont_byte());
            end
            default: add_byte(8'($urandom_range(8'hF5, 8'hFF)));
        endcase
    endtask

    // One character: mostly well-formed, some noise, broken and cut-short forms
    task automatic add_char();
        int              kind;
        int              n;
        int              keep;
        logic [3:0][7:0] s;
        kind = $urandom_range(0, 99);
        if (kind < 35)
        begin
            add_byte(8'($urandom_range(1, 127)));
        end
        else if (kind < 80)
        begin
            n = (kind < 55) ? 2 : (kind < 70) ? 3 : 4;
            s = make_valid(n);
            for (int k = 0; k < n; k++) add_byte(s[k]);
        end
        else if (kind < 88)
        begin
            add_byte(8'($urandom_range(1, 255)));
        end
        else if (kind < 94)
        begin
            add_bad();
        end
        else
        begin
            n    = $urandom_range(2, 4);
            s    = make_valid(n);
            keep = $urandom_range(1, n - 1);
            for (int k = 0; k < keep; k++) add_byte(s[k]);
        end
    endtask

    task automatic add_string(input int chars);
        for (int k = 0; k < chars; k++) add_char();
        add_byte(8'h00);
    endtask

    // Wait until every byte is in and every result out, then let the
    // sequencer finish anything that produced no result
    task automatic settle();
        while (sent_cnt != queued_cnt || clean_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_capacity(input logic [CAP_W-1:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [CAP_W-1:0] pick_capacity(input int phase);
        case (phase)
            0: return 13'd4096;
            1: return 13'd0;
            2: return 13'd1;
            3: return 13'd8191;
            4: return 13'd4097;
            default:
            begin
                case ($urandom_range(0, 9))
                    0:       return 13'd0;
                    1, 2, 3,
                    4:       return 13'($urandom_range(1, 24));
                    5, 6, 7: return 13'($urandom_range(25, 300));
                    8:       return 13'($urandom_range(0, 8191));
                    default: return 13'd4096;
                endcase
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin : main
        // ASCII extremes, smallest two-byte form, overlong leads, surrogate,
        // above U+10FFFF, illegal lead, lone continuation, a sequence cut
        // short mid-string, a valid four-byte form, a sequence cut short by
        // the end of the string
        logic [7:0] probe [22];
        int phase;
        int rnd_start;
        int strings;

        probe = '{8'h7F, 8'hC2, 8'h80, 8'hC1, 8'hE0, 8'h9F,
                  8'hED, 8'hA0, 8'hF4, 8'h90, 8'hFF, 8'h80,
                  8'hE2, 8'h82, 8'h01, 8'hF0, 8'h90, 8'h80,
                  8'h80, 8'hE2, 8'h82, 8'h00};

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, reset capacity first
        foreach (probe[i]) add_byte(probe[i]);
        settle();

        // Capacity zero: nothing at all, not even the terminator
        set_capacity(13'd0);
        add_byte(8'h41);
        add_byte(8'h00);
        settle();

        // Fit rule: one byte fits, the replacement fits, then output stops
        set_capacity(13'd5);
        add_byte(8'h41);
        add_byte(8'hFF);
        add_byte(8'h42);
        add_byte(8'h00);
        settle();

        // Capacity changed while a sequence is held: the new value applies
        set_capacity(13'd256);
        add_byte(8'h41);
        add_byte(8'hE2);
        add_byte(8'h82);
        settle();
        set_capacity(13'd3);
        add_byte(8'hAC);
        add_byte(8'h42);
        add_byte(8'h00);
        settle();

        // Random part; the first phase streams flat out into a squeezed receiver
        phase     = 0;
        rnd_start = queued_cnt;
        while (queued_cnt - rnd_start < RND_ITEMS)
        begin
            settle();
            set_capacity(pick_capacity(phase));
            if (phase == 0)
            begin
                tx_mode = IDLE_NONE;
                rx_mode = IDLE_NONE;
                for (int s = 0; s < 10; s++) add_string($urandom_range(8, 10));
                squeeze_go = 1'b1;
            end
            else
            begin
                tx_mode = $urandom_range(IDLE_NONE, IDLE_HARD);
                rx_mode = $urandom_range(IDLE_NONE, IDLE_HARD);
                strings = $urandom_range(2, 6);
                for (int s = 0; s < strings; s++) add_string($urandom_range(0, 10));
            end
            phase++;
        end

        settle();
        if (err_cnt == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
